FILE: rtl/trs_pkg.sv
package trs_pkg;

  // Length of a table key, in characters.
  localparam int unsigned KeyLen = 10;

  // Command codes on the input channel.
  localparam logic [2:0] CMD_TEXT  = 3'd0;
  localparam logic [2:0] CMD_KEY   = 3'd1;
  localparam logic [2:0] CMD_VALUE = 3'd2;
  localparam logic [2:0] CMD_ENTRY = 3'd3;
  localparam logic [2:0] CMD_FLUSH = 3'd4;

  localparam logic [7:0] ChNewline    = 8'h0A;
  localparam logic [7:0] ChUnderscore = 8'h5F;

  // Classification done by the front end.
  typedef enum logic [2:0] {
    K_WORD_CHAR,
    K_UNDERSCORE,
    K_OTHER_TEXT,
    K_KEY_WR,
    K_VAL_WR,
    K_ENTRY_SET,
    K_FLUSH,
    K_NONE
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [5:0] entry;
    logic [4:0] char_position;
    logic [5:0] value_len;
    logic       set_valid;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_VADDR,
    ST_VEMIT,
    ST_DUMP,
    ST_TAIL
  } state_e;

  function automatic logic is_alnum(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

endpackage

FILE: rtl/trs_front.sv
module trs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    cmd_i,
  input  logic [7:0]    data_byte_i,
  input  logic [5:0]    entry_i,
  input  logic [4:0]    char_position_i,
  input  logic [5:0]    value_len_i,
  input  logic          set_valid_i,
  input  logic          pop_i,
  output logic          item_valid_o,
  output trs_pkg::item_t item_o
);
  import trs_pkg::*;

  // Two-entry queue between the classifier and the back end.
  item_t      q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  item_t      cls;
  logic       push, pop;

  always_comb begin
    cls.data_byte     = data_byte_i;
    cls.entry         = entry_i;
    cls.char_position = char_position_i;
    cls.value_len     = value_len_i;
    cls.set_valid     = set_valid_i;
    unique case (cmd_i)
      CMD_TEXT: begin
        if (is_alnum(data_byte_i)) begin
          cls.kind = K_WORD_CHAR;
        end else if (data_byte_i == ChUnderscore) begin
          cls.kind = K_UNDERSCORE;
        end else begin
          cls.kind = K_OTHER_TEXT;
        end
      end
      CMD_KEY:   cls.kind = K_KEY_WR;
      CMD_VALUE: cls.kind = K_VAL_WR;
      CMD_ENTRY: cls.kind = K_ENTRY_SET;
      CMD_FLUSH: cls.kind = K_FLUSH;
      default:   cls.kind = K_NONE;
    endcase
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = pop_i && item_valid_o;
  assign item_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cls;
  end

endmodule

FILE: rtl/trs_back.sv
module trs_back #(
  parameter int unsigned NumEntries = 64,
  parameter int unsigned MaxValLen  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  trs_pkg::item_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           from_table_o,
  output logic           last_o
);
  import trs_pkg::*;

  localparam int unsigned EntW   = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam int unsigned VDepth = NumEntries * MaxValLen;
  localparam int unsigned VAddrW = (VDepth > 1) ? $clog2(VDepth) : 1;

  // Table storage.
  logic [7:0] key_mem [KeyLen][NumEntries];
  logic [5:0] len_mem [NumEntries];
  logic [7:0] val_mem [VDepth];
  logic       valid_q [NumEntries];

  // Word and line state.
  logic [KeyLen-1:0][7:0] word_buf_q, word_buf_d;
  logic [3:0] len_q, len_d;
  logic       spoiled_q, spoiled_d, inside_q, inside_d, line_open_q, line_open_d;

  // Sequencer state.
  state_e     state_q, state_d;
  logic [EntW-1:0] srch_idx_q, srch_idx_d, cmp_idx_q, hit_entry_q, hit_entry_d;
  logic       issue_done_q, issue_done_d, cmp_v_q, issue, hit;
  logic [KeyLen-1:0][7:0] key_rd_q;
  logic [5:0] len_rd_q;
  logic [7:0] val_rd_q;
  logic [5:0] vidx_q, vidx_d, vcnt_q, vcnt_d;
  logic [3:0] dcnt_q, dcnt_d, dlen_q, dlen_d;
  logic       tail_q, tail_d;
  logic [7:0] tail_byte_q, tail_byte_d;

  // Output register.
  logic       ovalid_q, ovalid_d, otbl_q, otbl_d, olast_q, olast_d;
  logic [7:0] obyte_q, obyte_d;

  logic       emit_ok, do_resolve;
  logic       key_we, val_we, ent_we;
  logic       ent_ok, eff_spoiled;
  logic [3:0] eff_len;
  logic [EntW-1:0]   ent_idx;
  logic [VAddrW-1:0] val_waddr, val_raddr;
  logic [5:0] vlen_sat;

  assign emit_ok   = !ovalid_q || out_ready_i;
  assign ent_ok    = {1'b0, item_i.entry} < 7'(NumEntries);
  assign ent_idx   = item_i.entry[EntW-1:0];
  assign val_waddr = VAddrW'(32'(ent_idx) * MaxValLen + 32'(item_i.char_position));
  assign val_raddr = VAddrW'(32'(hit_entry_q) * MaxValLen + 32'(vidx_q));
  assign vlen_sat  = (item_i.value_len > 6'(MaxValLen)) ? 6'(MaxValLen) : item_i.value_len;
  assign hit       = cmp_v_q && valid_q[cmp_idx_q] && (key_rd_q == word_buf_q);

  always_comb begin
    word_buf_d   = word_buf_q;
    len_d        = len_q;
    spoiled_d    = spoiled_q;
    inside_d     = inside_q;
    line_open_d  = line_open_q;
    state_d      = state_q;
    srch_idx_d   = srch_idx_q;
    issue_done_d = issue_done_q;
    hit_entry_d  = hit_entry_q;
    vidx_d       = vidx_q;
    vcnt_d       = vcnt_q;
    dcnt_d       = dcnt_q;
    dlen_d       = dlen_q;
    tail_d       = tail_q;
    tail_byte_d  = tail_byte_q;
    ovalid_d     = ovalid_q && !out_ready_i;
    obyte_d      = obyte_q;
    otbl_d       = otbl_q;
    olast_d      = olast_q;
    pop_o        = 1'b0;
    issue        = 1'b0;
    key_we       = 1'b0;
    val_we       = 1'b0;
    ent_we       = 1'b0;
    do_resolve   = 1'b0;
    eff_spoiled  = inside_q && spoiled_q;
    eff_len      = inside_q ? len_q : 4'd0;

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          pop_o       = 1'b1;
          tail_byte_d = item_i.data_byte;
          tail_d      = 1'b0;
          case (item_i.kind) inside
            K_WORD_CHAR, K_UNDERSCORE: begin
              inside_d    = 1'b1;
              line_open_d = 1'b1;
              if (eff_spoiled) begin
                tail_d  = 1'b1;
                state_d = ST_TAIL;
              end else if (item_i.kind == K_WORD_CHAR && eff_len < 4'(KeyLen)) begin
                word_buf_d[eff_len] = item_i.data_byte;
                len_d     = eff_len + 4'd1;
                spoiled_d = 1'b0;
              end else begin
                // Word too long or holding an underscore: flush what is buffered.
                tail_d    = 1'b1;
                spoiled_d = 1'b1;
                len_d     = 4'd0;
                dlen_d    = eff_len;
                dcnt_d    = 4'd0;
                state_d   = (eff_len == 4'd0) ? ST_TAIL : ST_DUMP;
              end
            end
            K_OTHER_TEXT: begin
              line_open_d = (item_i.data_byte != ChNewline);
              tail_d      = 1'b1;
              do_resolve  = 1'b1;
            end
            K_FLUSH: begin
              tail_byte_d = ChNewline;
              tail_d      = line_open_q;
              line_open_d = 1'b0;
              do_resolve  = 1'b1;
            end
            K_KEY_WR: key_we = ent_ok && (item_i.char_position < 5'(KeyLen));
            K_VAL_WR: val_we = ent_ok && ({1'b0, item_i.char_position} < 6'(MaxValLen));
            K_ENTRY_SET: ent_we = ent_ok;
            default: ;
          endcase
          if (do_resolve) begin
            inside_d  = 1'b0;
            spoiled_d = 1'b0;
            len_d     = 4'd0;
            if (inside_q && !spoiled_q) begin
              if (len_q == 4'(KeyLen)) begin
                srch_idx_d   = '0;
                issue_done_d = 1'b0;
                state_d      = ST_SEARCH;
              end else begin
                dlen_d  = len_q;
                dcnt_d  = 4'd0;
                state_d = ST_DUMP;
              end
            end else if (tail_d) begin
              state_d = ST_TAIL;
            end
          end
        end
      end
      ST_SEARCH: begin
        issue = !issue_done_q && !hit;
        if (issue) begin
          srch_idx_d = srch_idx_q + EntW'(1);
          if (srch_idx_q == EntW'(NumEntries - 1)) issue_done_d = 1'b1;
        end
        if (hit) begin
          hit_entry_d = cmp_idx_q;
          vcnt_d      = len_rd_q;
          vidx_d      = 6'd0;
          if (len_rd_q == 6'd0) begin
            state_d = tail_q ? ST_TAIL : ST_IDLE;
          end else begin
            state_d = ST_VADDR;
          end
        end else if (cmp_v_q && cmp_idx_q == EntW'(NumEntries - 1)) begin
          dlen_d  = 4'(KeyLen);
          dcnt_d  = 4'd0;
          state_d = ST_DUMP;
        end
      end
      ST_VADDR: state_d = ST_VEMIT;
      ST_VEMIT: begin
        if (emit_ok) begin
          ovalid_d = 1'b1;
          obyte_d  = val_rd_q;
          otbl_d   = 1'b1;
          olast_d  = (vidx_q == vcnt_q - 6'd1) && !tail_q;
          vidx_d   = vidx_q + 6'd1;
          if (vidx_q == vcnt_q - 6'd1) begin
            state_d = tail_q ? ST_TAIL : ST_IDLE;
          end else begin
            state_d = ST_VADDR;
          end
        end
      end
      ST_DUMP: begin
        if (emit_ok) begin
          ovalid_d = 1'b1;
          obyte_d  = word_buf_q[dcnt_q];
          otbl_d   = 1'b0;
          olast_d  = (dcnt_q == dlen_q - 4'd1) && !tail_q;
          dcnt_d   = dcnt_q + 4'd1;
          if (dcnt_q == dlen_q - 4'd1) state_d = tail_q ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (emit_ok) begin
          ovalid_d = 1'b1;
          obyte_d  = tail_byte_q;
          otbl_d   = 1'b0;
          olast_d  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      word_buf_q   <= '0;
      len_q        <= 4'd0;
      spoiled_q    <= 1'b0;
      inside_q     <= 1'b0;
      line_open_q  <= 1'b0;
      issue_done_q <= 1'b0;
      cmp_v_q      <= 1'b0;
      ovalid_q     <= 1'b0;
      for (int i = 0; i < NumEntries; i++) valid_q[i] <= 1'b0;
    end else begin
      state_q      <= state_d;
      word_buf_q   <= word_buf_d;
      len_q        <= len_d;
      spoiled_q    <= spoiled_d;
      inside_q     <= inside_d;
      line_open_q  <= line_open_d;
      issue_done_q <= issue_done_d;
      cmp_v_q      <= issue;
      ovalid_q     <= ovalid_d;
      if (ent_we) valid_q[ent_idx] <= item_i.set_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    srch_idx_q  <= srch_idx_d;
    cmp_idx_q   <= srch_idx_q;
    hit_entry_q <= hit_entry_d;
    vidx_q      <= vidx_d;
    vcnt_q      <= vcnt_d;
    dcnt_q      <= dcnt_d;
    dlen_q      <= dlen_d;
    tail_q      <= tail_d;
    tail_byte_q <= tail_byte_d;
    obyte_q     <= obyte_d;
    otbl_q      <= otbl_d;
    olast_q     <= olast_d;
  end

  // Table memories: one byte lane per key character, all read at the search index.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < KeyLen; k++) begin
      if (key_we && item_i.char_position == 5'(k)) key_mem[k][ent_idx] <= item_i.data_byte;
      key_rd_q[k] <= key_mem[k][srch_idx_q];
    end
    if (ent_we) len_mem[ent_idx] <= vlen_sat;
    len_rd_q <= len_mem[srch_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_waddr] <= item_i.data_byte;
    val_rd_q <= val_mem[val_raddr];
  end

  assign out_valid_o  = ovalid_q;
  assign out_byte_o   = obyte_q;
  assign from_table_o = otbl_q;
  assign last_o       = olast_q;

  a_cmp_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_v_q |-> state_q == ST_SEARCH) else $error("compare pending outside search");
  a_dump_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> dcnt_q < dlen_q) else $error("dump index out of range");
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_VEMIT |-> vidx_q < vcnt_q) else $error("value index out of range");
  a_word_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= 4'(KeyLen)) else $error("word buffer overrun");

endmodule

FILE: rtl/token_restore_substituter.sv
// Channel  | Direction | Contents
// s_axis   | in        | tuser = cmd, tdata = data_byte, entry, char_position, value_len,
//          |           |   set_valid
// m_axis   | out       | tdata = out_byte, tuser = from_table, tlast = last
//
// A beat is taken into a two-entry queue; the back end drains one queued item
// per cycle when it produces no output, so table loads and plain word characters run at
// one beat a cycle. Other items emit buffered text at one output beat per cycle while m_axis
// is ready, pass each restored value byte through an address and an emit state (value
// memory read), and read the key table entry by entry for a ten-character word. Reset
// clears the queue, word state and entry valid bits at once; key and value memories are
// not cleared. A stalled m_axis holds the back end, and the queue then backs up onto s_axis.
module token_restore_substituter #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned MAX_VALUE_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // data_byte, entry, char_position, value_len, set_valid
  input  logic [2:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic        m_axis_tuser,  // from_table
  output logic        m_axis_tlast
);
  import trs_pkg::*;

  // The entry field is six bits wide, so at most 64 entries can ever be addressed.
  localparam int unsigned NumEntries = (TABLE_ENTRIES < 64) ? TABLE_ENTRIES : 64;

  item_t item;
  logic  item_valid, pop;

  trs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .cmd_i          (s_axis_tuser),
    .data_byte_i    (s_axis_tdata[7:0]),
    .entry_i        (s_axis_tdata[13:8]),
    .char_position_i(s_axis_tdata[18:14]),
    .value_len_i    (s_axis_tdata[24:19]),
    .set_valid_i    (s_axis_tdata[25]),
    .pop_i          (pop),
    .item_valid_o   (item_valid),
    .item_o         (item)
  );

  trs_back #(
    .NumEntries(NumEntries),
    .MaxValLen (MAX_VALUE_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .from_table_o(m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

endmodule

FILE: sim/token_restore_checker.sv
// Watches both channels of the substituter, predicts the restored text from every
// accepted input beat and compares it with the output beats in order.
module token_restore_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_cnt_o,
  output int          pending_o
);
  import trs_pkg::*;

  localparam int unsigned Entries = 64;
  localparam int unsigned MaxVal  = 32;

  typedef struct packed {
    logic [7:0] ch;
    logic       tbl;
    logic       last;
  } text_beat_t;

  text_beat_t restored_q[$];
  text_beat_t step_q[$];

  logic [7:0] key_mem [Entries][KeyLen];
  logic [7:0] val_mem [Entries][MaxVal];
  logic [5:0] val_len [Entries];
  logic       ent_ok  [Entries];
  logic [7:0] word_buf [KeyLen];
  int unsigned word_len;
  logic       spoiled, in_word, line_open;

  function automatic void put(logic [7:0] b, logic t);
    text_beat_t x;
    x.ch = b;
    x.tbl = t;
    x.last = 1'b0;
    step_q.insert(step_q.size(), x);
  endfunction

  function automatic void dump_word();
    for (int i = 0; i < word_len; i++) put(word_buf[i], 1'b0);
  endfunction

  // Ends the pending word: a clean ten-character word may be replaced by a table value.
  function automatic void close_word();
    logic hit;
    logic same;
    if (in_word && !spoiled) begin
      hit = 1'b0;
      if (word_len == KeyLen) begin
        for (int e = 0; e < Entries && !hit; e++) begin
          same = ent_ok[e];
          for (int i = 0; i < KeyLen; i++) if (key_mem[e][i] != word_buf[i]) same = 1'b0;
          if (same) begin
            for (int i = 0; i < val_len[e]; i++) put(val_mem[e][i], 1'b1);
            hit = 1'b1;
          end
        end
      end
      if (!hit) dump_word();
    end
    in_word = 1'b0;
    spoiled = 1'b0;
    word_len = 0;
  endfunction

  function automatic void take_text(logic [7:0] b);
    logic an;
    an = is_alnum(b);
    line_open = (b != ChNewline);
    if (an || b == ChUnderscore) begin
      if (!in_word) begin
        in_word = 1'b1;
        spoiled = 1'b0;
        word_len = 0;
      end
      if (spoiled) begin
        put(b, 1'b0);
      end else if (an && word_len < KeyLen) begin
        word_buf[word_len] = b;
        word_len++;
      end else begin
        dump_word();
        word_len = 0;
        spoiled = 1'b1;
        put(b, 1'b0);
      end
    end else begin
      close_word();
      put(b, 1'b0);
    end
  endfunction

  function automatic void predict_restore(logic [2:0] cmd, logic [31:0] d);
    logic [7:0] b;
    logic [5:0] e;
    logic [4:0] pos;
    logic [5:0] len;
    b   = d[7:0];
    e   = d[13:8];
    pos = d[18:14];
    len = d[24:19];
    step_q.delete();
    case (cmd)
      CMD_TEXT: take_text(b);
      CMD_KEY: if (pos < KeyLen) key_mem[e][pos] = b;
      CMD_VALUE: val_mem[e][pos] = b;
      CMD_ENTRY: begin
        val_len[e] = (len > MaxVal) ? 6'(MaxVal) : len;
        ent_ok[e]  = d[25];
      end
      CMD_FLUSH: begin
        close_word();
        if (line_open) put(ChNewline, 1'b0);
        line_open = 1'b0;
      end
      default: ;
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) restored_q.insert(restored_q.size(), step_q[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_beat_t want;
    if (!rst_ni) begin
      for (int e = 0; e < Entries; e++) ent_ok[e] = 1'b0;
      for (int i = 0; i < KeyLen; i++) word_buf[i] = 8'h00;
      word_len = 0;
      spoiled = 1'b0;
      in_word = 1'b0;
      line_open = 1'b0;
      restored_q.delete();
      fail_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (restored_q.size() == 0) begin
          $error("unexpected output beat: byte %h", m_axis_tdata);
          fail_cnt_o++;
        end else begin
          want = restored_q.pop_front();
          if (m_axis_tdata != want.ch) begin
            $error("out_byte: expected %h, got %h", want.ch, m_axis_tdata);
            fail_cnt_o++;
          end
          if (m_axis_tuser != want.tbl) begin
            $error("from_table: expected %b, got %b", want.tbl, m_axis_tuser);
            fail_cnt_o++;
          end
          if (m_axis_tlast != want.last) begin
            $error("last: expected %b, got %b", want.last, m_axis_tlast);
            fail_cnt_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_restore(s_axis_tuser, s_axis_tdata);
      pending_o = restored_q.size();
    end
  end

endmodule

FILE: sim/tb_token_restore_substituter.sv
// Top of the testbench. It loads the key table, streams text through the block and
// gives the verdict; the checker beside the block does all prediction and comparison.
module tb_token_restore_substituter;
  import trs_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;  // data_byte, entry, char_position, value_len, set_valid
  logic [2:0]  s_axis_tuser;  // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;  // out_byte
  logic        m_axis_tuser;  // from_table
  logic        m_axis_tlast;

  int fail_cnt;
  int pending;
  int sent;
  int idle_cnt;
  logic quiet;

  // The table as the stimulus knows it. A valid entry must never expose a key or value
  // byte that was not written, so the written positions are tracked here.
  logic [7:0]  key_img [64][KeyLen];
  logic [9:0]  key_done [64];
  logic [31:0] val_done [64];
  logic        live [64];

  token_restore_substituter u_dut (.*);

  token_restore_checker u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  // The receiver stalls now and then, except inside the quiet stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 6);
  end

  // Ends the run if nothing moves on either channel for far longer than a slow
  // ten-character search followed by a full value under stalls could take.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt == 3000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // One beat on the input channel. The sender may hold tvalid low before it.
  task automatic send(input logic [2:0] cmd, input logic [31:0] d);
    while (!quiet && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  function automatic logic [31:0] pack(logic [7:0] b, logic [5:0] e, logic [4:0] p,
                                       logic [5:0] l, logic v);
    return {6'b0, v, l, p, e, b};
  endfunction

  // Text and flush beats carry random junk in the fields they do not use.
  task automatic txt(input logic [7:0] b);
    send(CMD_TEXT, pack(b, 6'($urandom), 5'($urandom), 6'($urandom), 1'($urandom)));
  endtask

  task automatic flush();
    send(CMD_FLUSH, pack(8'($urandom), 6'($urandom), 5'($urandom), 6'($urandom),
                         1'($urandom)));
  endtask

  task automatic put_key(input logic [5:0] e, input logic [4:0] p, input logic [7:0] b);
    send(CMD_KEY, pack(b, e, p, 6'($urandom), 1'($urandom)));
    if (p < KeyLen) begin
      key_img[e][p] = b;
      key_done[e][p] = 1'b1;
    end
  endtask

  task automatic put_val(input logic [5:0] e, input logic [4:0] p, input logic [7:0] b);
    send(CMD_VALUE, pack(b, e, p, 6'($urandom), 1'($urandom)));
    val_done[e][p] = 1'b1;
  endtask

  // Enabling is downgraded to disabling when the entry is not fully written.
  task automatic set_entry(input logic [5:0] e, input logic [5:0] len, input logic v);
    int n;
    logic [31:0] need;
    n = (len > 32) ? 32 : len;
    need = (n == 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 1);
    if (key_done[e] != 10'h3FF || (val_done[e] & need) != need) v = 1'b0;
    send(CMD_ENTRY, pack(8'($urandom), e, 5'($urandom), len, v));
    live[e] = v;
  endtask

  function automatic logic [7:0] rand_alnum();
    int k;
    k = $urandom_range(61);
    if (k < 10) return 8'h30 + 8'(k);
    if (k < 36) return 8'h41 + 8'(k - 10);
    return 8'h61 + 8'(k - 36);
  endfunction

  // Writes a fresh random key and value, then enables the entry.
  task automatic load_entry(input logic [5:0] e, input logic [5:0] len);
    int n;
    n = (len > 32) ? 32 : len;
    for (int i = 0; i < KeyLen; i++) put_key(e, 5'(i), rand_alnum());
    for (int i = 0; i < n; i++) put_val(e, 5'(i), 8'($urandom));
    set_entry(e, len, 1'b1);
  endtask

  task automatic send_key_word(input logic [5:0] e, input logic twist);
    int j;
    j = $urandom_range(KeyLen - 1);
    for (int i = 0; i < KeyLen; i++) txt((twist && i == j) ? rand_alnum() : key_img[e][i]);
  endtask

  task automatic separator();
    case ($urandom_range(5))
      0: txt(ChNewline);
      1: txt(8'($urandom_range(128, 255)));
      2: txt(8'($urandom));
      3: txt(8'h2E);
      default: txt(8'h20);
    endcase
  endtask

  // One chunk of random stimulus, weighted toward words that can hit the table.
  task automatic random_chunk();
    int r;
    int n;
    logic [5:0] e;
    r = $urandom_range(99);
    e = 6'($urandom_range(7));
    if (r < 40) begin
      if (!live[e]) e = 6'd0;
      send_key_word(e, 1'b0);
      separator();
    end else if (r < 48) begin
      send_key_word(e, 1'b1);
      separator();
    end else if (r < 60) begin
      n = $urandom_range(1, 14);
      for (int i = 0; i < n; i++) txt(rand_alnum());
      separator();
    end else if (r < 66) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) txt(($urandom_range(3) == 0) ? ChUnderscore : rand_alnum());
      separator();
    end else if (r < 72) begin
      separator();
    end else if (r < 77) begin
      flush();
    end else if (r < 80) begin
      send(3'($urandom_range(5, 7)), $urandom);
    end else if (r < 84) begin
      load_entry(6'($urandom_range(63)), 6'($urandom_range(0, 63)));
    end else if (r < 90) begin
      load_entry(e, 6'($urandom_range(0, 12)));
    end else if (r < 94) begin
      put_key(6'($urandom), 5'($urandom), rand_alnum());
    end else if (r < 97) begin
      put_val(6'($urandom), 5'($urandom), 8'($urandom));
    end else begin
      set_entry(6'($urandom), 6'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_TEXT;
    quiet = 1'b0;
    sent = 0;
    // Entries never loaded still get a known key image so that twisted words are clean text.
    for (int e = 0; e < 64; e++) begin
      key_done[e] = '0;
      val_done[e] = '0;
      live[e] = 1'b0;
      for (int i = 0; i < KeyLen; i++) key_img[e][i] = rand_alnum();
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Entries 0 and 1 share a key, so the lower one must win; entry 2
    // has an empty value and entry 3 asks for more than the longest value.
    load_entry(6'd0, 6'd3);
    for (int i = 0; i < KeyLen; i++) put_key(6'd1, 5'(i), key_img[0][i]);
    put_val(6'd1, 5'd0, 8'hFF);
    set_entry(6'd1, 6'd1, 1'b1);
    load_entry(6'd2, 6'd0);
    load_entry(6'd3, 6'd63);
    put_key(6'd63, 5'd31, 8'h00);  // position past the key is dropped
    put_val(6'd63, 5'd31, 8'hFF);
    send(3'd7, 32'hFFFF_FFFF);     // unknown command
    send_key_word(6'd0, 1'b0);
    txt(8'h20);
    send_key_word(6'd2, 1'b0);
    txt(8'hFF);
    send_key_word(6'd3, 1'b0);
    flush();                       // pending word and open line
    flush();                       // nothing left to close
    for (int i = 0; i < 11; i++) txt(rand_alnum());   // one character too long
    txt(ChNewline);
    txt(8'h61); txt(ChUnderscore); txt(8'h62);
    txt(8'h00);
    send_key_word(6'd0, 1'b0);
    set_entry(6'd0, 6'd3, 1'b0);   // disabling entry 0 exposes entry 1
    txt(8'h2C);
    send_key_word(6'd0, 1'b0);
    flush();

    // Hold the input until the output has drained completely once.
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);

    while (sent < 460) begin
      quiet = (sent >= 200 && sent < 330);
      random_chunk();
    end
    quiet = 1'b0;
    flush();
    s_axis_tvalid <= 1'b0;

    @(negedge clk_i);
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
